// ===== rtl/core/ssq_pkg.sv =====
// Shared types and constants for the sorted sleep/wakeup queue.
package ssq_pkg;

   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned WAKE_CNT_W  = $clog2(MAX_RESULTS + 1);

   localparam logic REQ_SLEEP = 1'b1;

   typedef enum logic [1:0] {
      ST_QUEUED   = 2'd0,
      ST_FULL     = 2'd1,
      ST_NONE_DUE = 2'd2,
      ST_WAKE     = 2'd3
   } ssq_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK_READ,
      S_TICK_EVAL,
      S_INS_STEP,
      S_INS_EVAL,
      S_EMIT
   } ssq_state_type;

   typedef struct packed {
      logic [63:0] deadline;
      logic [7:0]  id;
   } ssq_entry_type;

   typedef struct packed {
      logic           valid;
      ssq_status_type status;
      logic [7:0]     woken_id;
      logic [62:0]    tick_now;
      logic           last;
   } ssq_emit_type;

endpackage

// ===== rtl/core/sorted_sleep_wakeup_queue_unit.sv =====
// Top level of the sorted sleep/wakeup queue: stream ports, entry RAM and result register.
// Tick: after a read of the head entry, a nothing-due status, or one wake per cycle while the
//   result slot is free, up to 16 per tick; the next item is taken once the walk over the due
//   head entries ends. Sleep: the backward insert walk moves each later-deadline entry up one
//   slot, then writes the new entry; a full-queue reject skips the walk. The single RAM read
//   and write port paces both walks; output stalls add to this.
// Reset clears the tick counter, occupancy, ring head and result valid flag; RAM is untouched.
module sorted_sleep_wakeup_queue_unit #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // requester_id[7:0], sleep_ticks[39:8]
   input  logic [0:0]  req_tuser,  // req_type[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // woken_id[7:0], tick_now[70:8], zero[71]
   output logic [1:0]  rsp_tuser,  // status[1:0]
   output logic        rsp_tlast   // last_result
);

   localparam int unsigned ADDR_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned ENTRY_W = $bits(ssq_pkg::ssq_entry_type);

   ssq_pkg::ssq_emit_type   emit;
   logic                    out_free;
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr;
   logic [ENTRY_W-1:0]      ram_wdata;
   logic [ADDR_W-1:0]       ram_raddr;
   logic [ENTRY_W-1:0]      ram_rdata;

   logic                    rsp_valid_ff;
   ssq_pkg::ssq_status_type rsp_status_ff;
   logic [7:0]              rsp_id_ff;
   logic [62:0]             rsp_now_ff;
   logic                    rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   ssq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_type  (req_tuser[0]),
      .req_id    (req_tdata[7:0]),
      .req_ticks (req_tdata[39:8]),
      .req_ready (req_tready),
      .out_free  (out_free),
      .emit      (emit),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   ssq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Hold a result until its transfer; the sequencer only emits when the slot is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_status_ff <= emit.status;
         rsp_id_ff     <= emit.woken_id;
         rsp_now_ff    <= emit.tick_now;
         rsp_last_ff   <= emit.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_now_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/ssq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ssq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ssq_ctrl.sv =====
// Queue sequencer: tick counter, ring pointers, insert walk and wake walk over the RAM.
module ssq_ctrl #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_type,
   input  logic [7:0]                              req_id,
   input  logic [31:0]                             req_ticks,
   output logic                                    req_ready,
   input  logic                                    out_free,
   output ssq_pkg::ssq_emit_type                   emit,
   output logic                                    ram_we,
   output logic [$clog2(QUEUE_DEPTH)-1:0]          ram_waddr,
   output logic [$bits(ssq_pkg::ssq_entry_type)-1:0] ram_wdata,
   output logic [$clog2(QUEUE_DEPTH)-1:0]          ram_raddr,
   input  logic [$bits(ssq_pkg::ssq_entry_type)-1:0] ram_rdata
);

   localparam int unsigned ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);

   ssq_pkg::ssq_state_type  state_ff, state_in;
   logic [63:0]             now_ff, now_in;
   logic [ADDR_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]        occ_ff, occ_in;
   logic [CNT_W-1:0]        slot_ff, slot_in;
   logic [63:0]             new_dl_ff, new_dl_in;
   logic [7:0]              new_id_ff, new_id_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [7:0]              pend_id_ff, pend_id_in;
   logic [ssq_pkg::WAKE_CNT_W-1:0] wake_cnt_ff, wake_cnt_in;
   ssq_pkg::ssq_status_type single_st_ff, single_st_in;

   ssq_pkg::ssq_entry_type  rd_entry;
   ssq_pkg::ssq_entry_type  new_entry;
   logic [ADDR_W-1:0]       head_nxt;
   logic [ADDR_W-1:0]       rd_phys;
   logic [ADDR_W-1:0]       wr_phys;
   logic [CNT_W-1:0]        slot_m1;
   logic                    due;

   // Map head plus logical offset onto the ring; the sum stays below twice the depth.
   function automatic logic [ADDR_W-1:0] wrap_addr(input logic [CNT_W:0] sum);
      logic [CNT_W:0] r;
      r = (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) ? sum - (CNT_W + 1)'(QUEUE_DEPTH) : sum;
      return r[ADDR_W-1:0];
   endfunction

   assign rd_entry  = ssq_pkg::ssq_entry_type'(ram_rdata);
   assign new_entry = '{deadline: new_dl_ff, id: new_id_ff};
   assign head_nxt  = (head_ff == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign slot_m1   = slot_ff - 1'b1;
   assign rd_phys   = wrap_addr({{(CNT_W + 1 - ADDR_W){1'b0}}, head_ff} + {1'b0, slot_m1});
   assign wr_phys   = wrap_addr({{(CNT_W + 1 - ADDR_W){1'b0}}, head_ff} + {1'b0, slot_ff});

   assign due = (occ_ff != '0)
             && (wake_cnt_ff < ssq_pkg::WAKE_CNT_W'(ssq_pkg::MAX_RESULTS))
             && !($signed(now_ff) < $signed(rd_entry.deadline));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ssq_pkg::S_IDLE;
         now_ff        <= '0;
         head_ff       <= '0;
         occ_ff        <= '0;
         pend_valid_ff <= 1'b0;
         wake_cnt_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         head_ff       <= head_in;
         occ_ff        <= occ_in;
         pend_valid_ff <= pend_valid_in;
         wake_cnt_ff   <= wake_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      new_dl_ff    <= new_dl_in;
      new_id_ff    <= new_id_in;
      pend_id_ff   <= pend_id_in;
      single_st_ff <= single_st_in;
   end

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      head_in       = head_ff;
      occ_in        = occ_ff;
      slot_in       = slot_ff;
      new_dl_in     = new_dl_ff;
      new_id_in     = new_id_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      wake_cnt_in   = wake_cnt_ff;
      single_st_in  = single_st_ff;

      req_ready = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = wr_phys;
      ram_wdata = new_entry;
      ram_raddr = head_ff;

      emit          = '0;
      emit.tick_now = now_ff[62:0];

      unique case (state_ff)
         ssq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == ssq_pkg::REQ_SLEEP) begin
                  new_dl_in = now_ff + {{32{req_ticks[31]}}, req_ticks};
                  new_id_in = req_id;
                  slot_in   = occ_ff;
                  if (occ_ff == CNT_W'(QUEUE_DEPTH)) begin
                     single_st_in = ssq_pkg::ST_FULL;
                     state_in     = ssq_pkg::S_EMIT;
                  end else begin
                     state_in = ssq_pkg::S_INS_STEP;
                  end
               end else begin
                  now_in        = now_ff + 64'd1;
                  wake_cnt_in   = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ssq_pkg::S_TICK_READ;
               end
            end
         end
         ssq_pkg::S_TICK_READ: begin
            state_in = ssq_pkg::S_TICK_EVAL;
         end
         ssq_pkg::S_TICK_EVAL: begin
            // A woken entry is held in the pending register so its last flag can see the next entry.
            if (out_free) begin
               if (pend_valid_ff) begin
                  emit.valid    = 1'b1;
                  emit.status   = ssq_pkg::ST_WAKE;
                  emit.woken_id = pend_id_ff;
                  emit.last     = !due;
               end
               if (due) begin
                  pend_valid_in = 1'b1;
                  pend_id_in    = rd_entry.id;
                  head_in       = head_nxt;
                  occ_in        = occ_ff - 1'b1;
                  wake_cnt_in   = wake_cnt_ff + 1'b1;
                  ram_raddr     = head_nxt;
               end else begin
                  if (!pend_valid_ff) begin
                     emit.valid  = 1'b1;
                     emit.status = ssq_pkg::ST_NONE_DUE;
                     emit.last   = 1'b1;
                  end
                  pend_valid_in = 1'b0;
                  state_in      = ssq_pkg::S_IDLE;
               end
            end
         end
         ssq_pkg::S_INS_STEP: begin
            if (slot_ff == '0) begin
               ram_we       = 1'b1;
               occ_in       = occ_ff + 1'b1;
               single_st_in = ssq_pkg::ST_QUEUED;
               state_in     = ssq_pkg::S_EMIT;
            end else begin
               ram_raddr = rd_phys;
               state_in  = ssq_pkg::S_INS_EVAL;
            end
         end
         ssq_pkg::S_INS_EVAL: begin
            // Shift a strictly later entry up one slot, else drop the new one in here.
            ram_we = 1'b1;
            if ($signed(new_dl_ff) < $signed(rd_entry.deadline)) begin
               ram_wdata = rd_entry;
               slot_in   = slot_m1;
               state_in  = ssq_pkg::S_INS_STEP;
            end else begin
               occ_in       = occ_ff + 1'b1;
               single_st_in = ssq_pkg::ST_QUEUED;
               state_in     = ssq_pkg::S_EMIT;
            end
         end
         ssq_pkg::S_EMIT: begin
            if (out_free) begin
               emit.valid  = 1'b1;
               emit.status = single_st_ff;
               emit.last   = 1'b1;
               state_in    = ssq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ssq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/ssq_checker.sv =====
// Port-level checker for the sorted sleep/wakeup queue, bound to the top level.
module ssq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("ssq: stalled result changed");

   // Only wake results carry an id.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ssq_pkg::ST_WAKE) |-> rsp_tdata[7:0] == 8'd0)
      else $error("ssq: id on a non-wake result");

   // Status-only results always close their item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ssq_pkg::ST_WAKE) |-> rsp_tlast)
      else $error("ssq: non-wake result without last");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("ssq: result valid after reset");

endmodule

bind sorted_sleep_wakeup_queue_unit ssq_checker u_ssq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== test/sorted_sleep_wakeup_queue_unit_test.sv =====
// Stream-level test of the sorted sleep/wakeup queue against a behavioral timer-queue predictor.
module sorted_sleep_wakeup_queue_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned QUEUE_DEPTH  = 16;
   localparam int unsigned RANDOM_ITEMS = 232;
   localparam int unsigned DIR_ROWS     = 11;
   localparam int unsigned DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
   localparam logic        REQ_TICK     = ~ssq_pkg::REQ_SLEEP;

   typedef struct packed {
      logic                    kind;
      logic [7:0]              id;
      logic [31:0]             ticks;
      logic                    fixed;   // result given below instead of predicted
      ssq_pkg::ssq_status_type st;
      logic [62:0]             now;
   } timer_req_type;

   typedef struct packed {
      timer_req_type req;
      logic [4:0]    reps;       // id advances by one per repeat
   } table_row_type;

   typedef struct packed {
      ssq_pkg::ssq_status_type st;
      logic [7:0]              id;
      logic [62:0]             now;
      logic                    last;
   } wake_report_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // requester_id[7:0], sleep_ticks[39:8]
   logic [0:0]  req_tuser;   // req_type[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // woken_id[7:0], tick_now[70:8], zero[71]
   logic [1:0]  rsp_tuser;   // status[1:0]
   logic        rsp_tlast;

   // predictor state
   logic [63:0]            model_ticks;
   ssq_pkg::ssq_entry_type sleepers[$];
   wake_report_type        report_q[$];
   timer_req_type          sent_q[$];

   table_row_type directed_tab [DIR_ROWS];
   bit            gaps_enabled;
   int unsigned   items_sent;
   int unsigned   mismatches;
   int unsigned   wakes_seen;
   int unsigned   fulls_seen;
   int unsigned   empty_ticks;
   int unsigned   peak_occupancy;

   sorted_sleep_wakeup_queue_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic wake_report_type make_report(ssq_pkg::ssq_status_type st,
                                                   logic [7:0] id,
                                                   logic [63:0] now, logic last);
      wake_report_type r;
      r.st   = st;
      r.id   = id;
      r.now  = now[62:0];
      r.last = last;
      return r;
   endfunction

   // Apply one request to the sleeper list and queue the results it causes.
   function automatic void advance_timer_queue(timer_req_type req);
      logic [63:0]            deadline;
      int unsigned            pos;
      int unsigned            due;
      ssq_pkg::ssq_entry_type entry;
      if (req.kind == ssq_pkg::REQ_SLEEP) begin
         deadline = model_ticks + {{32{req.ticks[31]}}, req.ticks};
         if (sleepers.size() >= QUEUE_DEPTH) begin
            report_q.push_back(make_report(ssq_pkg::ST_FULL, 8'h00, model_ticks, 1'b1));
            fulls_seen++;
         end else begin
            pos = 0;
            // equal deadlines keep arrival order
            while (pos < sleepers.size() &&
                   !($signed(deadline) < $signed(sleepers[pos].deadline)))
               pos++;
            entry.deadline = deadline;
            entry.id       = req.id;
            sleepers.insert(pos, entry);
            if (sleepers.size() > peak_occupancy)
               peak_occupancy = sleepers.size();
            report_q.push_back(make_report(ssq_pkg::ST_QUEUED, 8'h00, model_ticks, 1'b1));
         end
      end else begin
         model_ticks = model_ticks + 64'd1;
         due = 0;
         while (due < sleepers.size() && due < ssq_pkg::MAX_RESULTS &&
                !($signed(model_ticks) < $signed(sleepers[due].deadline)))
            due++;
         if (due == 0) begin
            report_q.push_back(make_report(ssq_pkg::ST_NONE_DUE, 8'h00, model_ticks, 1'b1));
            empty_ticks++;
         end
         for (int unsigned i = 0; i < due; i++) begin
            entry = sleepers.pop_front();
            report_q.push_back(make_report(ssq_pkg::ST_WAKE, entry.id, model_ticks,
                                           i + 1 == due));
            wakes_seen++;
         end
      end
      if (req.fixed)
         report_q[$] = make_report(req.st, 8'h00, {1'b0, req.now}, 1'b1);
   endfunction

   function automatic void note_mismatch(string what, wake_report_type want,
                                         wake_report_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: want st=%0d id=%02h now=%0d last=%b, got st=%0d id=%02h now=%0d last=%b",
                  $realtime, what, want.st, want.id, want.now, want.last,
                  got.st, got.id, got.now, got.last);
   endfunction

   // Sample both channels on pre-edge values; predict on request transfers.
   always @(posedge clock) begin : watch
      wake_report_type got;
      wake_report_type want;
      if (!reset && req_tvalid && req_tready)
         advance_timer_queue(sent_q.pop_front());
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = make_report(ssq_pkg::ssq_status_type'(rsp_tuser), rsp_tdata[7:0],
                           {1'b0, rsp_tdata[70:8]}, rsp_tlast);
         if (report_q.size() == 0) begin
            note_mismatch("unexpected result", '0, got);
         end else begin
            want = report_q.pop_front();
            if (got != want)
               note_mismatch("result mismatch", want, got);
         end
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= !(gaps_enabled && $urandom_range(0, 99) < 9);
      end
   end

   function automatic timer_req_type make_req(logic kind, logic [7:0] id, logic [31:0] ticks);
      timer_req_type r;
      r       = '0;
      r.kind  = kind;
      r.id    = id;
      r.ticks = ticks;
      return r;
   endfunction

   function automatic logic [31:0] pick_sleep_ticks();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 10);
      if (roll < 85) return 32'd0 - $urandom_range(1, 10);
      if (roll < 94) return {1'b1, 31'($urandom)};
      if (roll < 96) return $urandom;
      if (roll < 99) return 32'h8000_0000;
      return 32'h7FFF_FFFF;
   endfunction

   task automatic send_item(timer_req_type req);
      while (gaps_enabled && $urandom_range(0, 99) < 9) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      sent_q.push_back(req);
      req_tvalid <= 1'b1;
      req_tuser  <= req.kind;
      req_tdata  <= {req.ticks, req.id};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
   endtask

   initial begin : stimulus
      timer_req_type req;
      int unsigned   directed_items;
      int unsigned   burst;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      gaps_enabled   = 1'b1;
      model_ticks    = '0;
      items_sent     = 0;
      mismatches     = 0;
      wakes_seen     = 0;
      fulls_seen     = 0;
      empty_ticks    = 0;
      peak_occupancy = 0;

      // empty tick, fill with already-due sleepers, overflow, wake all sixteen,
      // sign extremes of the sleep count, ties in arrival order
      directed_tab[0]  = '{'{REQ_TICK,          8'h00, 32'h0000_0000, 1'b1,
                             ssq_pkg::ST_NONE_DUE, 63'd1}, 5'd1};
      directed_tab[1]  = '{'{ssq_pkg::REQ_SLEEP, 8'hF0, 32'h0000_0000, 1'b1,
                             ssq_pkg::ST_QUEUED,   63'd1}, 5'd16};
      directed_tab[2]  = '{'{ssq_pkg::REQ_SLEEP, 8'hEE, 32'h0000_0005, 1'b1,
                             ssq_pkg::ST_FULL,     63'd1}, 5'd1};
      directed_tab[3]  = '{'{REQ_TICK,          8'hFF, 32'hFFFF_FFFF, 1'b0,
                             ssq_pkg::ST_WAKE,     63'd0}, 5'd1};
      directed_tab[4]  = '{'{ssq_pkg::REQ_SLEEP, 8'hFF, 32'h7FFF_FFFF, 1'b1,
                             ssq_pkg::ST_QUEUED,   63'd2}, 5'd1};
      directed_tab[5]  = '{'{ssq_pkg::REQ_SLEEP, 8'h00, 32'h8000_0000, 1'b1,
                             ssq_pkg::ST_QUEUED,   63'd2}, 5'd1};
      directed_tab[6]  = '{'{ssq_pkg::REQ_SLEEP, 8'hA5, 32'hFFFF_FFFF, 1'b1,
                             ssq_pkg::ST_QUEUED,   63'd2}, 5'd1};
      directed_tab[7]  = '{'{ssq_pkg::REQ_SLEEP, 8'h5A, 32'h0000_0002, 1'b1,
                             ssq_pkg::ST_QUEUED,   63'd2}, 5'd1};
      directed_tab[8]  = '{'{REQ_TICK,          8'h00, 32'h0000_0000, 1'b0,
                             ssq_pkg::ST_WAKE,     63'd0}, 5'd1};
      directed_tab[9]  = '{'{ssq_pkg::REQ_SLEEP, 8'h01, 32'h0000_0001, 1'b1,
                             ssq_pkg::ST_QUEUED,   63'd3}, 5'd2};
      directed_tab[10] = '{'{REQ_TICK,          8'h00, 32'h0000_0000, 1'b0,
                             ssq_pkg::ST_WAKE,     63'd0}, 5'd1};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int unsigned row = 0; row < DIR_ROWS; row++) begin
         for (int unsigned k = 0; k < directed_tab[row].reps; k++) begin
            req    = directed_tab[row].req;
            req.id = req.id + 8'(k);
            send_item(req);
         end
      end
      directed_items = items_sent;

      while (items_sent < directed_items + RANDOM_ITEMS) begin
         // hold both sides gap-free through a middle stretch
         gaps_enabled = !(items_sent >= directed_items + 100 &&
                          items_sent < directed_items + 170);
         if ($urandom_range(0, 9) < 2) begin
            // pile up near deadlines, then tick them out in batches
            burst = $urandom_range(8, 17);
            repeat (burst)
               send_item(make_req(ssq_pkg::REQ_SLEEP, 8'($urandom), $urandom_range(0, 3)));
            repeat ($urandom_range(1, 5))
               send_item(make_req(REQ_TICK, 8'($urandom), $urandom));
         end else if ($urandom_range(0, 1) == 0) begin
            send_item(make_req(ssq_pkg::REQ_SLEEP, 8'($urandom), pick_sleep_ticks()));
         end else begin
            send_item(make_req(REQ_TICK, 8'($urandom), $urandom));
         end
      end
      req_tvalid   <= 1'b0;
      gaps_enabled  = 1'b1;

      // wait until the last transfer has been predicted and every result seen
      while (report_q.size() != 0 || sent_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d directed): %0d wakes, %0d full rejections,",
               items_sent, directed_items, wakes_seen, fulls_seen);
      $display("%0d ticks with nothing due, peak queue occupancy %0d of %0d.",
               empty_ticks, peak_occupancy, QUEUE_DEPTH);
      if (mismatches == 0 && report_q.size() == 0 && sent_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
